// ===== rtl/core/mma_pkg.sv =====
// Package with the shared types and constants of the matrix multiply-accumulate engine.
`timescale 1ns / 1ps

package mma_pkg;

	localparam int MAX_DIM_DEF = 64;
	localparam int ROW_W       = 6;
	localparam int MODE_W      = 3;
	localparam int VAL_W       = 32;
	localparam int DIM_W       = 7;

	localparam logic [DIM_W-1:0] ACTIVE_DIM_RST = DIM_W'(64);

	typedef enum logic [MODE_W-1:0] {
		MODE_LOAD_A  = 3'd0,
		MODE_LOAD_B  = 3'd1,
		MODE_LOAD_C  = 3'd2,
		MODE_COMPUTE = 3'd3,
		MODE_READ_C  = 3'd4
	} mode_e;

	typedef enum logic {
		KIND_DONE = 1'b0,
		KIND_READ = 1'b1
	} kind_e;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [ROW_W-1:0]  row;
		logic [ROW_W-1:0]  col;
		logic [VAL_W-1:0]  element_value;
	} item_t;

	typedef struct packed {
		logic             kind;
		logic [VAL_W-1:0] result_value;
	} result_t;

endpackage

// ===== rtl/core/mma_ram.sv =====
// Simple dual-port memory with one write port and one registered read port.
`timescale 1ns / 1ps

module mma_ram #(
	parameter int ADDR_W = 12,
	parameter int DATA_W = 32
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== rtl/core/matrix_multiply_accumulate.sv =====
// Top level of the square matrix multiply-accumulate engine (C += A * B).
//
//  Channel   Direction  Handshake                  Payload
//  item      in         item_valid / item_ready    item_t   (mode, row, col, element_value)
//  result    out        result_valid / result_ready result_t (kind, result_value)
//  cfg       in         cfg_wr_en, no wait         cfg_wr_data (active_dim)
//
// A read of C passes through the registered read port of C and then the result register, where it
// waits while the result channel is stalled. A compute of dimension n issues one pair of reads of
// A and B per cycle over i, j and k, then drains the multiply and accumulate stages.
// Reset clears the control state only; memory contents are undefined until written.
// Items are taken only while the sequencer is idle; a waiting result stalls completion.
`timescale 1ns / 1ps

module matrix_multiply_accumulate
	import mma_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  item_t            item,
	output logic             result_valid,
	input  logic             result_ready,
	output result_t          result,
	input  logic             cfg_wr_en,
	input  logic [DIM_W-1:0] cfg_wr_data
);

	localparam int IDX_W  = $clog2(MAX_DIM);
	localparam int ADDR_W = 2 * IDX_W;
	localparam int XW     = ((IDX_W > ROW_W) ? IDX_W : ROW_W) + 2;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_READ  = 4'b0010,
		ST_COMP  = 4'b0100,
		ST_DRAIN = 4'b1000
	} state_e;

	typedef struct packed {
		logic              valid;
		logic              first;
		logic              last;
		logic [ADDR_W-1:0] addr;
	} tag_t;

	state_e            state_q;
	logic [DIM_W-1:0]  active_dim_q;
	logic [IDX_W-1:0]  nm1_q;
	logic [IDX_W-1:0]  i_q;
	logic [IDX_W-1:0]  j_q;
	logic [IDX_W-1:0]  k_q;
	logic              inside_q;
	logic              result_valid_q;
	result_t           result_q;

	tag_t              tag_s1;
	tag_t              tag_s2;
	logic [VAL_W-1:0]  prod_s2;
	logic [VAL_W-1:0]  c_s2;
	logic [VAL_W-1:0]  acc_q;
	logic [VAL_W-1:0]  acc_sum;

	logic              accept;
	logic              out_free;
	logic              res_load;
	logic [XW-1:0]     row_x;
	logic [XW-1:0]     col_x;
	logic [XW-1:0]     dim_x;
	logic [XW-1:0]     n_x;
	logic              item_inside;
	logic [ADDR_W-1:0] item_addr;
	logic              in_comp;
	logic              k_last;
	logic              j_last;
	logic              i_last;

	logic              a_we;
	logic              b_we;
	logic              c_we;
	logic [ADDR_W-1:0] c_waddr;
	logic [VAL_W-1:0]  c_wdata;
	logic              c_re;
	logic [ADDR_W-1:0] c_raddr;
	logic [VAL_W-1:0]  a_rd;
	logic [VAL_W-1:0]  b_rd;
	logic [VAL_W-1:0]  c_rd;

	assign item_ready   = (state_q == ST_IDLE);
	assign accept       = item_valid && item_ready;
	assign out_free     = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign res_load     = out_free && ((state_q == ST_READ) ||
	                      ((state_q == ST_DRAIN) && !tag_s1.valid && !tag_s2.valid));

	assign row_x       = XW'(item.row);
	assign col_x       = XW'(item.col);
	assign dim_x       = XW'(MAX_DIM);
	assign item_inside = (row_x < dim_x) && (col_x < dim_x);
	assign item_addr   = {row_x[IDX_W-1:0], col_x[IDX_W-1:0]};
	assign n_x         = (XW'(active_dim_q) > dim_x) ? dim_x : XW'(active_dim_q);

	assign in_comp = (state_q == ST_COMP);
	assign k_last  = (k_q == nm1_q);
	assign j_last  = (j_q == nm1_q);
	assign i_last  = (i_q == nm1_q);

	assign a_we    = accept && (item.mode == MODE_LOAD_A) && item_inside;
	assign b_we    = accept && (item.mode == MODE_LOAD_B) && item_inside;
	assign c_we    = (accept && (item.mode == MODE_LOAD_C) && item_inside) ||
	                 (tag_s2.valid && tag_s2.last);
	assign c_waddr = tag_s2.valid ? tag_s2.addr : item_addr;
	assign c_wdata = tag_s2.valid ? acc_sum : item.element_value;
	assign c_re    = in_comp || (accept && (item.mode == MODE_READ_C) && item_inside);
	assign c_raddr = in_comp ? {i_q, j_q} : item_addr;

	assign acc_sum = (tag_s2.first ? c_s2 : acc_q) + prod_s2;

	mma_ram #(.ADDR_W(ADDR_W), .DATA_W(VAL_W)) u_ram_a (
		.clk     (clk),
		.wr_en   (a_we),
		.wr_addr (item_addr),
		.wr_data (item.element_value),
		.rd_en   (in_comp),
		.rd_addr ({i_q, k_q}),
		.rd_data (a_rd)
	);

	mma_ram #(.ADDR_W(ADDR_W), .DATA_W(VAL_W)) u_ram_b (
		.clk     (clk),
		.wr_en   (b_we),
		.wr_addr (item_addr),
		.wr_data (item.element_value),
		.rd_en   (in_comp),
		.rd_addr ({k_q, j_q}),
		.rd_data (b_rd)
	);

	mma_ram #(.ADDR_W(ADDR_W), .DATA_W(VAL_W)) u_ram_c (
		.clk     (clk),
		.wr_en   (c_we),
		.wr_addr (c_waddr),
		.wr_data (c_wdata),
		.rd_en   (c_re),
		.rd_addr (c_raddr),
		.rd_data (c_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_dim_q <= ACTIVE_DIM_RST;
		end else if (cfg_wr_en) begin
			active_dim_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
			tag_s1         <= '0;
			tag_s2         <= '0;
		end else begin
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
			tag_s1.valid <= in_comp;
			tag_s1.first <= (k_q == '0);
			tag_s1.last  <= k_last;
			tag_s1.addr  <= {i_q, j_q};
			tag_s2       <= tag_s1;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (item.mode)
							MODE_READ_C: state_q <= ST_READ;
							MODE_COMPUTE: begin
								state_q <= (n_x == '0) ? ST_DRAIN : ST_COMP;
							end
							default: state_q <= ST_IDLE;
						endcase
					end
				end
				ST_READ: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_COMP: begin
					if (k_last && j_last && i_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!tag_s1.valid && !tag_s2.valid && out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			inside_q <= item_inside;
			nm1_q    <= IDX_W'(n_x - XW'(1));
			i_q      <= '0;
			j_q      <= '0;
			k_q      <= '0;
		end else if (in_comp) begin
			if (k_last) begin
				k_q <= '0;
				if (j_last) begin
					j_q <= '0;
					i_q <= i_q + IDX_W'(1);
				end else begin
					j_q <= j_q + IDX_W'(1);
				end
			end else begin
				k_q <= k_q + IDX_W'(1);
			end
		end
		if (state_q == ST_READ && out_free) begin
			result_q.kind         <= KIND_READ;
			result_q.result_value <= inside_q ? c_rd : '0;
		end else if (state_q == ST_DRAIN && out_free) begin
			result_q.kind         <= KIND_DONE;
			result_q.result_value <= '0;
		end
		prod_s2 <= a_rd * b_rd;
		c_s2    <= c_rd;
		if (tag_s2.valid) begin
			acc_q <= acc_sum;
		end
	end

endmodule
